>>> src/csd_pkg.sv
// Shared types and constants for the cosine similarity and distance block.
package csd_pkg;

    // Longest vector the accumulator widths hold without saturating.
    localparam int MAX_LEN = 1024;

    localparam int ELEM_W = 16;
    localparam int DOT_W  = 42;
    localparam int SQ_W   = 41;
    localparam int DIFF_W = 43;
    localparam int COS_W  = 16;
    localparam int DIST_W = 21;
    localparam int ROOT_W = 22;
    localparam int QUO_W  = 15;
    localparam int COS_ONE = 16384;

    typedef struct packed {
        logic signed [ELEM_W-1:0] x_elem;
        logic signed [ELEM_W-1:0] y_elem;
        logic                     last_elem;
    } csd_in_t;

    typedef struct packed {
        logic signed [COS_W-1:0]  cosine_value;
        logic        [DIST_W-1:0] distance_value;
        logic                     zero_norm;
    } csd_out_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_ROOT,
        ST_CHECK,
        ST_DIVIDE,
        ST_OUTPUT
    } csd_state_t;

    typedef struct packed {
        logic accumulate;
        logic start_root;
        logic root_step;
        logic start_div;
        logic div_step;
        logic finish;
    } csd_cmd_t;

    typedef struct packed {
        logic root_done;
        logic skip_div;
        logic div_done;
    } csd_status_t;

endpackage

>>> src/csd_datapath.sv
// Datapath: accumulators, three bit-serial square roots and a restoring divider.
module csd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csd_pkg::csd_cmd_t    cmd,
    input  csd_pkg::csd_in_t     in_item,
    input  logic [15:0]          norm_floor,
    output csd_pkg::csd_status_t status,
    output csd_pkg::csd_out_t    out_item
);
    import csd_pkg::*;

    localparam int RSTEPS = 22;  // two radicand bits per step, 44-bit radicands
    localparam int DSTEPS = 15;  // quotient bits; larger ratios are caught up front

    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [SQ_W-1:0]   xsq_reg, xsq_next, ysq_reg, ysq_next;
    logic [DIFF_W-1:0] dsq_reg, dsq_next;

    // Square root working registers (remainder, root, radicand shifter) per lane.
    logic [ROOT_W+1:0] rem_reg [3], rem_next [3];
    logic [ROOT_W-1:0] root_reg [3], root_next [3];
    logic [43:0]       rad_reg [3], rad_next [3];
    logic [4:0]        rcnt_reg, rcnt_next;

    logic [55:0] dnum_reg, dnum_next;
    logic [43:0] den_reg, den_next;
    logic [44:0] drem_reg, drem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [3:0]  dcnt_reg, dcnt_next;
    logic        neg_reg, neg_next;
    logic        zn_reg, zn_next;
    logic        ovf_reg, ovf_next;

    logic signed [31:0] prod_xy;
    logic [31:0] prod_xx, prod_yy;
    logic signed [ELEM_W:0] diff;
    logic [ELEM_W-1:0] dmag;
    logic [31:0] prod_dd;
    logic signed [DOT_W:0] dot_sum;
    logic [SQ_W:0] xsum, ysum;
    logic [DIFF_W:0] dsum;
    logic [DOT_W-1:0] dot_mag;
    logic [ROOT_W+1:0] trial [3];
    logic [44:0] dtrial;
    logic [QUO_W-1:0] cos_mag;
    logic zn_calc;

    always_comb
    begin
        prod_xy = 32'(in_item.x_elem) * 32'(in_item.y_elem);
        prod_xx = 32'(in_item.x_elem) * 32'(in_item.x_elem);
        prod_yy = 32'(in_item.y_elem) * 32'(in_item.y_elem);
        diff = {in_item.x_elem[ELEM_W-1], in_item.x_elem}
             - {in_item.y_elem[ELEM_W-1], in_item.y_elem};
        dmag = diff[ELEM_W] ? ELEM_W'(-diff) : ELEM_W'(diff);
        prod_dd = 32'(dmag) * 32'(dmag);
        dot_sum = {dot_reg[DOT_W-1], dot_reg} + (DOT_W+1)'(prod_xy);
        xsum = {1'b0, xsq_reg} + (SQ_W+1)'(prod_xx);
        ysum = {1'b0, ysq_reg} + (SQ_W+1)'(prod_yy);
        dsum = {1'b0, dsq_reg} + (DIFF_W+1)'(prod_dd);
        // The finished dot product is held in the numerator register.
        dot_mag = dnum_reg[DOT_W-1] ? DOT_W'(-dnum_reg[DOT_W-1:0])
                                    : dnum_reg[DOT_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {rem_reg[i][ROOT_W-1:0], rad_reg[i][43:42]}
                     - {root_reg[i], 2'b01};
        end
        dtrial = {drem_reg[43:0], dnum_reg[55]} - {1'b0, den_reg};
        zn_calc = (root_reg[0] == '0) || (root_reg[1] == '0)
               || (root_reg[0] < ROOT_W'(norm_floor))
               || (root_reg[1] < ROOT_W'(norm_floor));
        cos_mag = (ovf_reg || (quo_reg > QUO_W'(COS_ONE))) ? QUO_W'(COS_ONE) : quo_reg;
    end

    always_comb
    begin
        dot_next = dot_reg;
        xsq_next = xsq_reg;
        ysq_next = ysq_reg;
        dsq_next = dsq_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        rad_next = rad_reg;
        rcnt_next = rcnt_reg;
        dnum_next = dnum_reg;
        den_next = den_reg;
        drem_next = drem_reg;
        quo_next = quo_reg;
        dcnt_next = dcnt_reg;
        neg_next = neg_reg;
        zn_next = zn_reg;
        ovf_next = ovf_reg;
        if (cmd.accumulate)
        begin
            if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
                dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                          : {1'b0, {(DOT_W-1){1'b1}}};
            else
                dot_next = dot_sum[DOT_W-1:0];
            xsq_next = xsum[SQ_W] ? '1 : xsum[SQ_W-1:0];
            ysq_next = ysum[SQ_W] ? '1 : ysum[SQ_W-1:0];
            dsq_next = dsum[DIFF_W] ? '1 : dsum[DIFF_W-1:0];
        end
        if (cmd.start_root)
        begin
            rad_next[0] = 44'(xsum[SQ_W] ? {SQ_W{1'b1}} : xsum[SQ_W-1:0]);
            rad_next[1] = 44'(ysum[SQ_W] ? {SQ_W{1'b1}} : ysum[SQ_W-1:0]);
            rad_next[2] = 44'(dsum[DIFF_W] ? {DIFF_W{1'b1}} : dsum[DIFF_W-1:0]);
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = '0;
                root_next[i] = '0;
            end
            rcnt_next = '0;
            neg_next = dot_sum[DOT_W];
            // Keep the final dot product for the divider; accumulators clear.
            dnum_next = 56'(dot_sum[DOT_W] != dot_sum[DOT_W-1]
                ? (dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                  : {1'b0, {(DOT_W-1){1'b1}}})
                : dot_sum[DOT_W-1:0]);
            dot_next = '0;
            xsq_next = '0;
            ysq_next = '0;
            dsq_next = '0;
        end
        if (cmd.root_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!trial[i][ROOT_W+1])
                begin
                    rem_next[i] = trial[i];
                    root_next[i] = {root_reg[i][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = {rem_reg[i][ROOT_W-1:0], rad_reg[i][43:42]};
                    root_next[i] = {root_reg[i][ROOT_W-2:0], 1'b0};
                end
                rad_next[i] = {rad_reg[i][41:0], 2'b00};
            end
            rcnt_next = rcnt_reg + 5'd1;
        end
        if (cmd.start_div)
        begin
            zn_next = zn_calc;
            den_next = root_reg[0] * root_reg[1];
            // Divide |dot| << 14: the upper bits seed the remainder and the low
            // 15 bits are shifted in, one quotient bit per step.
            drem_next = 45'({dot_mag, 14'd0} >> DSTEPS);
            dnum_next = 56'({dot_mag, 14'd0}) << (56 - DSTEPS);
            quo_next = '0;
            dcnt_next = '0;
            ovf_next = 1'b0;
        end
        if (cmd.div_step)
        begin
            // A starting remainder at or above the divisor means the ratio is
            // two or more, so the cosine saturates.
            if (dcnt_reg == '0)
                ovf_next = (drem_reg >= {1'b0, den_reg});
            if (!dtrial[44])
            begin
                drem_next = dtrial;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                drem_next = {drem_reg[43:0], dnum_reg[55]};
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            dnum_next = {dnum_reg[54:0], 1'b0};
            dcnt_next = dcnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            xsq_reg <= '0;
            ysq_reg <= '0;
            dsq_reg <= '0;
            rcnt_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            xsq_reg <= xsq_next;
            ysq_reg <= ysq_next;
            dsq_reg <= dsq_next;
            rcnt_reg <= rcnt_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        rad_reg <= rad_next;
        dnum_reg <= dnum_next;
        den_reg <= den_next;
        drem_reg <= drem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        zn_reg <= zn_next;
        ovf_reg <= ovf_next;
    end

    assign status.root_done = (rcnt_reg == 5'(RSTEPS - 1)) && cmd.root_step;
    assign status.skip_div = zn_calc;
    assign status.div_done = (dcnt_reg == 4'(DSTEPS - 1)) && cmd.div_step;

    always_comb
    begin
        out_item.zero_norm = zn_reg;
        out_item.cosine_value = zn_reg ? '0
            : (neg_reg ? COS_W'(-{1'b0, cos_mag}) : COS_W'({1'b0, cos_mag}));
        out_item.distance_value = (root_reg[2] > ROOT_W'((1 << DIST_W) - 1))
            ? '1 : DIST_W'(root_reg[2]);
    end

endmodule

>>> src/csd_control.sv
// Controller: sequences accumulation, root extraction, division and result hand-off.
module csd_control (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 last_elem,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  csd_pkg::csd_status_t status,
    output csd_pkg::csd_cmd_t    cmd
);
    import csd_pkg::*;

    csd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCUM;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (last_elem)
                    begin
                        cmd.start_root = 1'b1;
                        state_next = ST_ROOT;
                    end
                    else
                        cmd.accumulate = 1'b1;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.start_div = 1'b1;
                state_next = status.skip_div ? ST_OUTPUT : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_ACCUM;
            end
            default: state_next = ST_ACCUM;
        endcase
    end

endmodule

>>> src/cosine_similarity_and_distance.sv
// Top level of the cosine similarity and Euclidean distance block.
//
// Element pairs are taken one per cycle while a vector streams in; each
// request adds x*y, x*x, y*y and (x-y)^2 into saturating accumulators. The
// request marked last starts the result: three bit-serial square roots run
// side by side, a check state compares the norms against norm_floor and
// forms the denominator, then a restoring divider runs (it is skipped when a
// norm is zero or below the floor). The next vector's first pair is accepted
// once the result has been taken. The root and check states plus the
// divider dominate short vectors.
module cosine_similarity_and_distance (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  csd_pkg::csd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output csd_pkg::csd_out_t out_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);
    import csd_pkg::*;

    // Accumulator widths are sized for vectors of up to MAX_LEN pairs;
    // longer vectors saturate.

    logic [15:0] norm_floor_reg;
    csd_cmd_t    cmd;
    csd_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_floor_reg <= 16'd1;
        else if (cfg_we)
            norm_floor_reg <= cfg_wdata;
    end

    csd_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_elem (in_data.last_elem),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    csd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_item    (in_data),
        .norm_floor (norm_floor_reg),
        .status     (status),
        .out_item   (out_data)
    );

endmodule

>>> src/csd_checker.sv
// Port-level checker for the cosine similarity and distance block.
module csd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input csd_pkg::csd_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input csd_pkg::csd_out_t out_data
);
    import csd_pkg::*;

    // A result request holds until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Cosine stays within plus or minus one.
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.cosine_value <= 16'sd16384)
                   && (out_data.cosine_value >= -16'sd16384))
        else $error("cosine out of range");

    // A flagged norm forces the cosine to zero.
    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_norm |-> out_data.cosine_value == '0)
        else $error("cosine nonzero with small norm");

    // No input is taken while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    // Accepting a last request drops in_ready while the result computes.
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_elem |=> !in_ready)
        else $error("input accepted during result computation");

endmodule

bind cosine_similarity_and_distance csd_checker u_csd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> bench/tb_cosine_similarity_and_distance.sv
// Self-checking testbench for the cosine similarity and distance block.
module tb_cosine_similarity_and_distance;
    timeunit 1ns;
    timeprecision 1ps;

    import csd_pkg::*;

    localparam longint DOT_HI   = (64'sd1 <<< 41) - 1;
    localparam longint DOT_LO   = -DOT_HI - 1;
    localparam longint SQ_HI    = (64'sd1 <<< 41) - 1;
    localparam longint DIFF_HI  = (64'sd1 <<< 43) - 1;
    localparam longint DIST_HI  = 2097151;
    localparam int     RAND_ITEMS = 420;
    localparam longint CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    csd_in_t   in_data;
    logic      out_valid;
    logic      out_ready;
    csd_out_t  out_data;
    logic      cfg_we;
    logic [15:0] cfg_wdata;

    cosine_similarity_and_distance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // The clock runs 5 ns high and 5 ns low.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Requests waiting to be driven, and results the predictor expects.
    csd_in_t   pending_reqs[$];
    csd_out_t  expected_results[$];
    int        mismatch_count = 0;
    longint    cycle_count = 0;
    int        results_seen = 0;
    int        reqs_sent = 0;

    // Predictor state: its own copy of the accumulators and of the floor.
    logic [15:0] floor_model;
    longint      dot_sum;
    longint      xsq_sum;
    longint      ysq_sum;
    longint      dsq_sum;

    // Integer square root, floored, by the usual bit-pair method.
    function automatic longint int_sqrt(input longint v);
        longint r;
        longint b;
        begin
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > v)
                b = b >>> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        end
    endfunction

    function automatic longint add_clamped(input longint acc, input longint p,
                                           input longint hi);
        begin
            if (p > hi - acc)
                return hi;
            return acc + p;
        end
    endfunction

    // Folds one request into the accumulators; on the last pair it pushes
    // the expected cosine, distance and floor flag and clears the sums.
    task automatic predict_similarity(input csd_in_t req);
        longint xv;
        longint yv;
        longint dm;
        longint s;
        longint nx;
        longint ny;
        longint mag;
        longint dist_val;
        longint cosv;
        logic   below;
        csd_out_t res;
        begin
            xv = longint'(req.x_elem);
            yv = longint'(req.y_elem);
            dm = xv - yv;
            if (dm < 0)
                dm = -dm;
            s = dot_sum + xv * yv;
            if (s > DOT_HI)
                s = DOT_HI;
            if (s < DOT_LO)
                s = DOT_LO;
            dot_sum = s;
            xsq_sum = add_clamped(xsq_sum, xv * xv, SQ_HI);
            ysq_sum = add_clamped(ysq_sum, yv * yv, SQ_HI);
            dsq_sum = add_clamped(dsq_sum, dm * dm, DIFF_HI);
            if (req.last_elem)
            begin
                nx = int_sqrt(xsq_sum);
                ny = int_sqrt(ysq_sum);
                below = (nx == 0) || (ny == 0) || (nx < longint'(floor_model))
                        || (ny < longint'(floor_model));
                cosv = 0;
                if (!below)
                begin
                    mag = (dot_sum < 0) ? -dot_sum : dot_sum;
                    mag = (mag <<< 14) / (nx * ny);
                    if (mag > COS_ONE)
                        mag = COS_ONE;
                    cosv = (dot_sum < 0) ? -mag : mag;
                end
                dist_val = int_sqrt(dsq_sum);
                if (dist_val > DIST_HI)
                    dist_val = DIST_HI;
                res.cosine_value   = cosv[15:0];
                res.distance_value = dist_val[20:0];
                res.zero_norm      = below;
                expected_results.push_back(res);
                dot_sum = 0;
                xsq_sum = 0;
                ysq_sum = 0;
                dsq_sum = 0;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
            mismatch_count++;
        end
    endtask

    // Driver: takes the next request from the queue after a random gap and
    // holds it steady until the block accepts it.
    int in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // Hold the request until it is taken.
        end
        else
        begin
            if (in_valid)
            begin
                predict_similarity(in_data);
                reqs_sent++;
            end
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_data  <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                // At least a quarter of the time the gaps vanish, so that bursts run.
                in_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: compares every accepted result with the oldest expectation
    // and lowers ready for a random number of cycles after each one.
    int out_stall = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    csd_out_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (out_data.cosine_value !== exp_res.cosine_value)
                        report_mismatch($sformatf("cosine %0d, expected %0d",
                            out_data.cosine_value, exp_res.cosine_value));
                    if (out_data.distance_value !== exp_res.distance_value)
                        report_mismatch($sformatf("distance %0d, expected %0d",
                            out_data.distance_value, exp_res.distance_value));
                    if (out_data.zero_norm !== exp_res.zero_norm)
                        report_mismatch($sformatf("zero_norm %0b, expected %0b",
                            out_data.zero_norm, exp_res.zero_norm));
                end
                out_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // A random element, weighted toward small magnitudes and the extremes so
    // that the norm floor and the saturated cosine both come into play.
    function automatic logic [15:0] pick_elem();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'(int'($urandom_range(0, 8)) - 4);
                3, 4:    return 16'(int'($urandom_range(0, 1024)) - 512);
                default: return 16'($urandom);
            endcase
        end
    endfunction

    task automatic queue_pair(input logic [15:0] xv, input logic [15:0] yv,
                              input logic lst);
        csd_in_t req;
        begin
            req.x_elem    = xv;
            req.y_elem    = yv;
            req.last_elem = lst;
            pending_reqs.push_back(req);
        end
    endtask

    // Writes the floor while the block is idle; the predictor follows.
    task automatic write_floor(input logic [15:0] value);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
            floor_model = value;
        end
    endtask

    // Waits until every request is taken and every result has arrived, then
    // lets the block sit idle before the next step.
    task automatic wait_drained();
        begin
            while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
                @(posedge clk);
            repeat (60) @(posedge clk);
        end
    endtask

    // Queues a burst of random vectors; most are short, a few long.
    task automatic queue_random_vectors(input int count);
        int left;
        int len;
        begin
            left = count;
            while (left > 0)
            begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(1, 64);
                    1:       len = 1;
                    default: len = $urandom_range(1, 12);
                endcase
                if (len > left)
                    len = left;
                for (int i = 0; i < len; i++)
                begin
                    // A y equal to x now and then gives distance zero and
                    // a cosine of one; its negation gives minus one.
                    logic [15:0] xv;
                    logic [15:0] yv;
                    xv = pick_elem();
                    case ($urandom_range(0, 7))
                        0:       yv = xv;
                        1:       yv = -xv;
                        default: yv = pick_elem();
                    endcase
                    queue_pair(xv, yv, i == len - 1);
                end
                left -= len;
            end
        end
    endtask

    // Timeout watchdog.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int floors[6];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        floor_model = 16'd1;
        dot_sum = 0;
        xsq_sum = 0;
        ysq_sum = 0;
        dsq_sum = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset floor: extremes, identical and opposite
        // vectors, a zero vector, and a single-pair vector.
        queue_pair(16'h7FFF, 16'h7FFF, 1'b1);
        queue_pair(16'h8000, 16'h7FFF, 1'b1);
        queue_pair(16'h8000, 16'h8000, 1'b1);
        queue_pair(16'h0000, 16'h0100, 1'b1);
        queue_pair(16'h0100, 16'h0000, 1'b0);
        queue_pair(16'h0000, 16'h0100, 1'b1);
        queue_pair(16'h0003, 16'hFFFD, 1'b0);
        queue_pair(16'hFFFF, 16'h0001, 1'b1);
        queue_pair(16'h0001, 16'h0001, 1'b1);
        queue_pair(16'h5555, 16'hAAAA, 1'b0);
        queue_pair(16'hAAAA, 16'h5555, 1'b1);
        wait_drained();

        // Floor of zero: a zero norm must still raise the flag.
        write_floor(16'h0000);
        queue_pair(16'h0000, 16'h0000, 1'b1);
        queue_pair(16'h0000, 16'h0200, 1'b1);
        queue_pair(16'h0010, 16'h0020, 1'b1);
        wait_drained();

        // Highest floor: both vectors here, even the one of three extreme pairs, are forced to zero.
        write_floor(16'hFFFF);
        queue_pair(16'h7FFF, 16'h7FFF, 1'b0);
        queue_pair(16'h7FFF, 16'h7FFF, 1'b0);
        queue_pair(16'h7FFF, 16'h7FFF, 1'b1);
        queue_pair(16'h0100, 16'h0100, 1'b1);
        wait_drained();

        // Random part over several floors; then one vector of the full length
        // drives the x and y squared sums to or near their largest values.
        floors = '{1, 0, 65535, 256, 40, 4096};
        for (int p = 0; p < 6; p++)
        begin
            write_floor(16'(floors[p]));
            queue_random_vectors(RAND_ITEMS / 6);
            wait_drained();
        end
        write_floor(16'd1);
        for (int i = 0; i < 1024; i++)
            queue_pair(16'h8000, (i % 2 == 0) ? 16'h7FFF : 16'h8000, i == 1023);
        wait_drained();

        $display("Drove %0d element pairs and checked %0d results", reqs_sent, results_seen);
        $display("across six norm floors, a full-length vector and idle/stall patterns.");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
